// File: rtl/core/segsub_pkg.sv
// shared types and constants for the segment box subdivider
package segsub_pkg;

  localparam int COORD_W     = 32;
  localparam int NUM_AXES    = 3;
  localparam int NUM_LANES   = 2 * NUM_AXES;
  localparam int NUM_IN      = 2 * NUM_LANES;
  localparam int MAX_SEG     = 64;
  localparam int CNT_W       = 7;
  localparam int IDX_W       = 6;
  localparam int STEP_W      = COORD_W + 2;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_CYCLES  = COORD_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  localparam int IN_DATA_W   = NUM_IN * COORD_W;
  localparam int OUT_RAW_W   = NUM_LANES * COORD_W + IDX_W;
  localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic REG_N_SEGMENTS = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_SLICE
  } segsub_state_t;

  typedef struct packed {
    logic             load;
    logic             div_step;
    logic             fix;
    logic             advance;
    logic [IDX_W-1:0] k;
    logic             last;
    logic [CNT_W-1:0] n;
  } segsub_cmd_t;

  typedef struct packed {
    logic out_stall;
  } segsub_status_t;

endpackage

// File: rtl/core/segsub_lane.sv
// one bound lane: per-link floor division of the span, then stepping per slice
module segsub_lane (
  input  logic                               clk,
  input  segsub_pkg::segsub_cmd_t            cmd,
  input  logic signed [segsub_pkg::COORD_W-1:0] p,
  input  logic signed [segsub_pkg::COORD_W-1:0] d,
  output logic signed [segsub_pkg::COORD_W-1:0] v_cur,
  output logic signed [segsub_pkg::COORD_W-1:0] v_next
);

  logic [segsub_pkg::COORD_W-1:0]       dvd;
  logic [segsub_pkg::CNT_W-1:0]         rem;
  logic                                 neg;
  logic signed [segsub_pkg::STEP_W-1:0] qstep;
  logic [segsub_pkg::CNT_W-1:0]         rstep;
  logic [segsub_pkg::CNT_W-1:0]         r_cur;

  logic signed [segsub_pkg::COORD_W:0]  delta;
  logic signed [segsub_pkg::COORD_W:0]  delta_neg;
  logic [segsub_pkg::COORD_W-1:0]       dvd_step;
  logic [segsub_pkg::CNT_W-1:0]         rem_step;
  logic [segsub_pkg::CNT_W:0]           r_sum;
  logic                                 carry;
  logic [segsub_pkg::CNT_W-1:0]         r_next;
  logic signed [segsub_pkg::STEP_W-1:0] v_sum;
  logic [segsub_pkg::STEP_W-1:0]        qmag;

  assign delta     = {d[segsub_pkg::COORD_W-1], d} - {p[segsub_pkg::COORD_W-1], p};
  assign delta_neg = -delta;

  // restoring division, a few quotient bits per cycle
  always_comb begin
    dvd_step = dvd;
    rem_step = rem;
    for (int i = 0; i < segsub_pkg::DIV_RADIX_BITS; i++) begin
      rem_step = {rem_step[segsub_pkg::CNT_W-2:0], dvd_step[segsub_pkg::COORD_W-1]};
      dvd_step = {dvd_step[segsub_pkg::COORD_W-2:0], 1'b0};
      if (rem_step >= cmd.n) begin
        rem_step    = rem_step - cmd.n;
        dvd_step[0] = 1'b1;
      end
    end
  end

  assign qmag = {2'b00, dvd};

  // next bound: add the step quotient and carry the remainder
  assign r_sum  = {1'b0, r_cur} + {1'b0, rstep};
  assign carry  = (r_sum >= {1'b0, cmd.n});
  assign r_next = carry ? segsub_pkg::CNT_W'(r_sum - {1'b0, cmd.n})
                        : r_sum[segsub_pkg::CNT_W-1:0];
  assign v_sum  = {{2{v_cur[segsub_pkg::COORD_W-1]}}, v_cur} + qstep
                  + segsub_pkg::STEP_W'(carry);
  assign v_next = v_sum[segsub_pkg::COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg   <= delta[segsub_pkg::COORD_W];
      dvd   <= delta[segsub_pkg::COORD_W] ? delta_neg[segsub_pkg::COORD_W-1:0]
                                          : delta[segsub_pkg::COORD_W-1:0];
      rem   <= '0;
      v_cur <= p;
      r_cur <= '0;
    end else if (cmd.div_step) begin
      dvd <= dvd_step;
      rem <= rem_step;
    end else if (cmd.fix) begin
      // turn the magnitude quotient into a floor quotient with remainder in [0, n)
      if (!neg) begin
        qstep <= qmag;
        rstep <= rem;
      end else if (rem == '0) begin
        qstep <= -qmag;
        rstep <= '0;
      end else begin
        qstep <= ~qmag;
        rstep <= cmd.n - rem;
      end
    end else if (cmd.advance) begin
      v_cur <= v_next;
      r_cur <= r_next;
    end
  end

endmodule

// File: rtl/core/segsub_datapath.sv
// six bound lanes, slice min/max and the output register
module segsub_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  segsub_pkg::segsub_cmd_t             cmd,
  output segsub_pkg::segsub_status_t          status,
  input  logic [segsub_pkg::IN_DATA_W-1:0]    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [segsub_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                                out_last
);

  logic signed [segsub_pkg::COORD_W-1:0] v_cur  [segsub_pkg::NUM_LANES];
  logic signed [segsub_pkg::COORD_W-1:0] v_next [segsub_pkg::NUM_LANES];
  logic signed [segsub_pkg::COORD_W-1:0] bound  [segsub_pkg::NUM_LANES];
  logic signed [segsub_pkg::COORD_W-1:0] out_coord [segsub_pkg::NUM_LANES];
  logic [segsub_pkg::IDX_W-1:0]          out_idx;

  for (genvar i = 0; i < segsub_pkg::NUM_LANES; i++) begin : g_lane
    segsub_lane u_lane (
      .clk    (clk),
      .cmd    (cmd),
      .p      (in_data[i*segsub_pkg::COORD_W +: segsub_pkg::COORD_W]),
      .d      (in_data[(i+segsub_pkg::NUM_LANES)*segsub_pkg::COORD_W +: segsub_pkg::COORD_W]),
      .v_cur  (v_cur[i]),
      .v_next (v_next[i])
    );

    // lower bounds take the minimum, upper bounds the maximum
    if (i < segsub_pkg::NUM_AXES) begin : g_lo
      assign bound[i] = (v_next[i] < v_cur[i]) ? v_next[i] : v_cur[i];
    end else begin : g_hi
      assign bound[i] = (v_next[i] > v_cur[i]) ? v_next[i] : v_cur[i];
    end

    assign out_data[i*segsub_pkg::COORD_W +: segsub_pkg::COORD_W] = out_coord[i];
  end

  assign out_data[segsub_pkg::NUM_LANES*segsub_pkg::COORD_W +: segsub_pkg::IDX_W] = out_idx;
  assign out_data[segsub_pkg::OUT_DATA_W-1:segsub_pkg::OUT_RAW_W] = '0;

  assign status.out_stall = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      for (int i = 0; i < segsub_pkg::NUM_LANES; i++) begin
        out_coord[i] <= bound[i];
      end
      out_idx  <= cmd.k;
      out_last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/segsub_ctrl.sv
// controller: accept, divide, fix up, then one slice per output transfer
module segsub_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [segsub_pkg::CNT_W-1:0]  n_segments,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  segsub_pkg::segsub_status_t    status,
  output segsub_pkg::segsub_cmd_t       cmd
);

  segsub_pkg::segsub_state_t         state, state_next;
  logic [segsub_pkg::DIV_CNT_W-1:0]  cnt, cnt_next;
  logic [segsub_pkg::IDX_W-1:0]      k, k_next;
  logic [segsub_pkg::CNT_W-1:0]      n, n_next;
  logic [segsub_pkg::CNT_W-1:0]      n_eff;

  // zero acts as one, anything above the maximum is clamped
  always_comb begin
    if (n_segments == '0) begin
      n_eff = segsub_pkg::CNT_W'(1);
    end else if (n_segments > segsub_pkg::CNT_W'(segsub_pkg::MAX_SEG)) begin
      n_eff = segsub_pkg::CNT_W'(segsub_pkg::MAX_SEG);
    end else begin
      n_eff = n_segments;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    k_next       = k;
    n_next       = n;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.fix      = 1'b0;
    cmd.advance  = 1'b0;
    cmd.k        = k;
    cmd.n        = n;
    cmd.last     = (({1'b0, k} + segsub_pkg::CNT_W'(1)) == n);
    case (state)
      segsub_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          n_next     = n_eff;
          cnt_next   = '0;
          state_next = segsub_pkg::ST_DIV;
        end
      end
      segsub_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + segsub_pkg::DIV_CNT_W'(1);
        if (cnt == segsub_pkg::DIV_CNT_W'(segsub_pkg::DIV_CYCLES - 1)) begin
          state_next = segsub_pkg::ST_FIX;
        end
      end
      segsub_pkg::ST_FIX: begin
        cmd.fix    = 1'b1;
        k_next     = '0;
        state_next = segsub_pkg::ST_SLICE;
      end
      segsub_pkg::ST_SLICE: begin
        if (!status.out_stall) begin
          cmd.advance = 1'b1;
          if (cmd.last) begin
            state_next = segsub_pkg::ST_IDLE;
          end else begin
            k_next = k + segsub_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = segsub_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= segsub_pkg::ST_IDLE;
      cnt   <= '0;
      k     <= '0;
      n     <= segsub_pkg::CNT_W'(1);
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
      n     <= n_next;
    end
  end

endmodule

// File: rtl/core/segment_box_subdivider.sv
// Splits a link given as proximal and distal Q16.16 boxes into n_segments slice boxes.
// A link is handled in steps: the controller takes the transfer, a 4-bit-per-cycle divider
// splits each of the six bound spans by n into a quotient and remainder, a fix-up state
// turns them into floor form, then an add-and-carry stepper in each lane gives one slice
// per cycle while the output is not stalled. Slices leave through a single output
// register and m_tlast marks the final slice. The next link is taken the cycle after the
// last slice enters the output register. n_segments of 0 acts as 1, above 64 as 64.
module segment_box_subdivider (
  input  logic                                clk,
  input  logic                                rst,
  // apb configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [segsub_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [segsub_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [segsub_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // prox_lo_x, prox_lo_y, prox_lo_z, prox_hi_x, prox_hi_y, prox_hi_z,
  // dist_lo_x, dist_lo_y, dist_lo_z, dist_hi_x, dist_hi_y, dist_hi_z (32 bits each)
  input  logic [segsub_pkg::IN_DATA_W-1:0]    s_tdata,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z (32 bits each),
  // slice_index (6 bits), zero fill (2 bits)
  output logic [segsub_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                m_tlast
);

  logic [segsub_pkg::CNT_W-1:0] n_segments;
  segsub_pkg::segsub_cmd_t      cmd;
  segsub_pkg::segsub_status_t   status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_segments <= segsub_pkg::CNT_W'(1);
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == segsub_pkg::REG_N_SEGMENTS) begin
      n_segments <= pwdata[segsub_pkg::CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == segsub_pkg::REG_N_SEGMENTS)
                  ? segsub_pkg::APB_DATA_W'(n_segments) : '0;

  segsub_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .n_segments (n_segments),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .status     (status),
    .cmd        (cmd)
  );

  segsub_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

`ifndef SYNTHESIS
  // the final slice of a link carries index n - 1
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    cmd.advance && cmd.last |=>
      ({1'b0, m_tdata[segsub_pkg::NUM_LANES*segsub_pkg::COORD_W +: segsub_pkg::IDX_W]}
       + segsub_pkg::CNT_W'(1)) == $past(cmd.n))
    else $error("last slice index does not match slice count");

  // no new link is taken while slices are still being produced
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && cmd.advance))
    else $error("input taken while slicing");

  // a slice loaded into the output register is presented the next cycle
  a_slice_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |=> m_tvalid)
    else $error("slice lost from output register");

  // the first slice after a link is taken has index zero
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |=> cmd.k == '0)
    else $error("slice index not cleared at link start");
`endif

endmodule

// File: test/segment_box_subdivider_test.sv
// stream testbench for the segment box subdivider: directed table, random links, scoreboard
module segment_box_subdivider_test;
  timeunit 1ns;
  timeprecision 1ps;

  import segsub_pkg::*;

  localparam int REG_UNUSED = 1;     // no register lives here, writes must be dropped
  localparam int LO_BASE = 0;
  localparam int HI_BASE = NUM_AXES * COORD_W;
  localparam int IDX_BASE = NUM_LANES * COORD_W;

  typedef logic [NUM_IN-1:0][COORD_W-1:0] link_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] lo;
    logic [NUM_AXES-1:0][COORD_W-1:0] hi;
    logic [IDX_W-1:0]                 idx;
    logic                             last;
  } slice_t;

  typedef struct {
    logic [CNT_W-1:0] nseg;
    link_t            link;
    bit               typed;
    slice_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tlast;

  segment_box_subdivider uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  logic [CNT_W-1:0] nseg_cfg = 7'd1;
  slice_t pending_slices[$];
  dir_row_t dir_rows[$];
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int fail_count = 0;
  int link_count = 0;
  int slice_count = 0;
  int setting_count = 0;
  string axis_name[NUM_AXES] = '{"x", "y", "z"};

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // interpolate one bound at k/n, rounding toward minus infinity
  function automatic longint lerp_floor(longint p, longint d, longint k, longint n);
    longint num, q;
    num = (d - p) * k;
    q = num / n;
    if ((num % n) != 0 && num < 0) q = q - 1;
    return p + q;
  endfunction

  task automatic push_slice_boxes(input link_t link);
    longint n, pl, ph, dl, dh, l0, l1, h0, h1;
    slice_t s;
    n = nseg_cfg;
    if (n < 1) n = 1;
    if (n > MAX_SEG) n = MAX_SEG;
    for (int k = 0; k < n; k++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        pl = $signed(link[a]);
        ph = $signed(link[a + NUM_AXES]);
        dl = $signed(link[a + NUM_LANES]);
        dh = $signed(link[a + NUM_LANES + NUM_AXES]);
        l0 = lerp_floor(pl, dl, k, n);
        l1 = lerp_floor(pl, dl, k + 1, n);
        h0 = lerp_floor(ph, dh, k, n);
        h1 = lerp_floor(ph, dh, k + 1, n);
        s.lo[a] = COORD_W'(l0 < l1 ? l0 : l1);
        s.hi[a] = COORD_W'(h0 > h1 ? h0 : h1);
      end
      s.idx = IDX_W'(k);
      s.last = (k == n - 1);
      pending_slices.push_back(s);
    end
  endtask

  function automatic link_t mk_link(logic [31:0] pl, logic [31:0] ph,
                                    logic [31:0] dl, logic [31:0] dh);
    link_t l;
    for (int a = 0; a < NUM_AXES; a++) begin
      l[a] = pl;
      l[a + NUM_AXES] = ph;
      l[a + NUM_LANES] = dl;
      l[a + NUM_LANES + NUM_AXES] = dh;
    end
    return l;
  endfunction

  // single-slice box, what any link gives with one slice
  function automatic slice_t mk_box(logic [31:0] lo, logic [31:0] hi);
    slice_t s;
    for (int a = 0; a < NUM_AXES; a++) begin
      s.lo[a] = lo;
      s.hi[a] = hi;
    end
    s.idx = '0;
    s.last = 1'b1;
    return s;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return 32'($urandom_range(0, 400000)) - 32'd200000;
      default: return $urandom();
    endcase
  endfunction

  function automatic link_t pick_link();
    link_t l;
    for (int i = 0; i < NUM_IN; i++) l[i] = pick_coord();
    // mostly nearby boxes: distal a short step from proximal
    if ($urandom_range(0, 2) != 0) begin
      for (int i = 0; i < NUM_LANES; i++)
        l[i + NUM_LANES] = l[i] + 32'($urandom_range(0, 131072)) - 32'd65536;
    end
    return l;
  endfunction

  task automatic reg_write(input int index, input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * index);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (index == int'(REG_N_SEGMENTS)) nseg_cfg = data[CNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic reg_check(input int index, input logic [APB_DATA_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'(4 * index);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("n_segments readback expected %0d got %0d", want, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_slices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_slice_count(input logic [CNT_W-1:0] n);
    drain();
    reg_write(int'(REG_N_SEGMENTS), {(APB_DATA_W - CNT_W)'($urandom()), n});
    reg_check(int'(REG_N_SEGMENTS), APB_DATA_W'(n));
    setting_count++;
  endtask

  // leaves s_tvalid high after the transfer so back-to-back links need no gap
  task automatic send_link(input link_t link);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= link;
    do @(posedge clk); while (!s_tready);
    link_count++;
  endtask

  // receiver: random stalls per slice, one long hold-off on request
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    slice_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.lo = m_tdata[LO_BASE +: NUM_AXES * COORD_W];
      got.hi = m_tdata[HI_BASE +: NUM_AXES * COORD_W];
      got.idx = m_tdata[IDX_BASE +: IDX_W];
      got.last = m_tlast;
      slice_count++;
      if (pending_slices.size() == 0) begin
        $error("slice transfer with no link pending");
        fail_count++;
      end else begin
        want = pending_slices.pop_front();
        for (int a = 0; a < NUM_AXES; a++) begin
          if (got.lo[a] !== want.lo[a]) begin
            $error("out_lo_%s expected %h got %h", axis_name[a], want.lo[a], got.lo[a]);
            fail_count++;
          end
          if (got.hi[a] !== want.hi[a]) begin
            $error("out_hi_%s expected %h got %h", axis_name[a], want.hi[a], got.hi[a]);
            fail_count++;
          end
        end
        if (got.idx !== want.idx) begin
          $error("slice_index expected %0d got %0d", want.idx, got.idx);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last_slice expected %0d got %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic [31:0] CMAX = 32'h7FFF_FFFF;

  initial begin
    static logic [CNT_W-1:0] phase_n[11] = '{7'd2, 7'd5, 7'd3, 7'd16, 7'd64, 7'd1, 7'd0,
                                             7'd127, 7'd7, 7'd33, 7'd4};
    static int phase_items[11] = '{30, 30, 30, 25, 8, 30, 15, 6, 30, 8, 30};
    dir_row_t r;

    // one slice after reset: the box spans both ends
    dir_rows.push_back('{7'd1, mk_link(0, 0, 0, 0), 1, mk_box(0, 0)});
    dir_rows.push_back('{7'd1, mk_link(CMAX, CMAX, CMAX, CMAX), 1, mk_box(CMAX, CMAX)});
    dir_rows.push_back('{7'd1, mk_link(CMIN, CMIN, CMIN, CMIN), 1, mk_box(CMIN, CMIN)});
    dir_rows.push_back('{7'd1, mk_link(CMIN, CMIN, CMAX, CMAX), 1, mk_box(CMIN, CMAX)});
    // swapped bounds pass through unchecked
    dir_rows.push_back('{7'd1, mk_link(32'h0005_0000, 32'hFFFF_0000, 32'h0003_0000,
                         32'hFFFE_0000), 1, mk_box(32'h0003_0000, 32'hFFFF_0000)});
    // zero count behaves as one slice
    dir_rows.push_back('{7'd0, mk_link(CMAX, CMAX, CMIN, CMIN), 1, mk_box(CMIN, CMAX)});
    dir_rows.push_back('{7'd0, mk_link(32'h0001_8000, 32'h0002_0000, 32'hFFFE_8000, 0), 1,
                         mk_box(32'hFFFE_8000, 32'h0002_0000)});
    // full count, widest spans both ways, rounding on tiny spans
    dir_rows.push_back('{7'd64, mk_link(CMIN, CMIN, CMAX, CMAX), 0, '0});
    dir_rows.push_back('{7'd64, mk_link(CMAX, CMAX, CMIN, CMIN), 0, '0});
    dir_rows.push_back('{7'd64, mk_link(0, 0, 32'hFFFF_FFFF, 1), 0, '0});
    // count above the limit clamps
    dir_rows.push_back('{7'd127, mk_link(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
                         32'hAAAA_AAAA), 0, '0});
    dir_rows.push_back('{7'd3, mk_link(0, 0, 32'hFFFF_FFFE, 32'h0000_0002), 0, '0});
    dir_rows.push_back('{7'd3, mk_link(32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF), 0, '0});
    dir_rows.push_back('{7'd2, mk_link(CMIN, CMAX, CMAX, CMIN), 0, '0});
    dir_rows.push_back('{7'd7, mk_link(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                         32'h0001_0000), 0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.nseg != nseg_cfg) set_slice_count(r.nseg);
      send_link(r.link);
      if (r.typed) pending_slices.push_back(r.want);
      else push_slice_boxes(r.link);
    end

    // a write to an unmapped register must leave the slice count alone
    drain();
    reg_write(REG_UNUSED, 32'd50);
    reg_check(int'(REG_N_SEGMENTS), APB_DATA_W'(nseg_cfg));

    foreach (phase_n[p]) begin
      set_slice_count(phase_n[p]);
      idle_on = (p != 5 && p != 8);
      if (p == 2) hold_req = 1'b1;
      repeat (phase_items[p]) begin
        link_t l;
        l = pick_link();
        send_link(l);
        push_slice_boxes(l);
      end
    end

    drain();
    repeat (80) @(posedge clk);
    $display("run covered %0d links and %0d slice boxes over %0d slice-count settings",
             link_count, slice_count, setting_count);
    $display("settings included zero, one, the maximum and beyond it, with stalls both sides");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
